// ----- src/shs_pkg.sv -----
// shared types and constants of the instrumented shellsort unit
`timescale 1ns / 1ps

package shs_pkg;

    localparam int MAX_LEN    = 4096;
    localparam int MAX_GAPS   = 6;
    localparam int HIST_BINS  = 64;
    localparam int DATA_WIDTH = 32;

    localparam int IDX_W      = 12;
    localparam int LEN_W      = 13;
    localparam int GAP_W      = 12;
    localparam int CNT_W      = 3;
    localparam int BIN_W      = 6;
    localparam int LVL_W      = 13;
    localparam int HIST_DEPTH = MAX_GAPS * 2 * HIST_BINS;
    localparam int HADDR_W    = $clog2(HIST_DEPTH);

    // request codes
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_RUN   = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_HIST  = 2'd3;

    // register indexes
    localparam logic [2:0] REG_LENGTH = 3'd0;
    localparam logic [2:0] REG_GCOUNT = 3'd1;
    localparam logic [2:0] REG_GAP0   = 3'd2;
    localparam logic [2:0] REG_GAP1   = 3'd3;
    localparam logic [2:0] REG_GAP2   = 3'd4;
    localparam logic [2:0] REG_GAP3   = 3'd5;
    localparam logic [2:0] REG_GAP4   = 3'd6;
    localparam logic [2:0] REG_GAP5   = 3'd7;

    typedef struct packed {
        logic [LEN_W-1:0]                 array_length;
        logic [CNT_W-1:0]                 gap_count;
        logic [MAX_GAPS-1:0][GAP_W-1:0]   gap;
    } cfg_t;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [IDX_W-1:0]      elem_index;
        logic [DATA_WIDTH-1:0] elem_value;
        logic [2:0]            pass_select;
        logic                  hist_kind;
        logic [BIN_W-1:0]      bin_index;
    } req_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] read_data;
        logic [31:0]           bin_count;
        logic [LVL_W-1:0]      max_level;
        logic                  status;
    } res_t;

endpackage

// ----- src/shs_ram.sv -----
// single-port ram with registered read data
`timescale 1ns / 1ps

module shs_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // read-first port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- src/shs_ctrl.sv -----
// request decoder and shellsort sequencer with histogram update
`timescale 1ns / 1ps

module shs_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  shs_pkg::cfg_t                     cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  shs_pkg::req_t                     req,
    output logic                              out_valid,
    input  logic                              out_ready,
    output shs_pkg::res_t                     res,
    output logic                              e_we,
    output logic [shs_pkg::IDX_W-1:0]         e_addr,
    output logic [shs_pkg::DATA_WIDTH-1:0]    e_wdata,
    input  logic [shs_pkg::DATA_WIDTH-1:0]    e_rdata,
    output logic                              h_we,
    output logic [shs_pkg::HADDR_W-1:0]       h_addr,
    output logic [31:0]                       h_wdata,
    input  logic [31:0]                       h_rdata
);

    typedef enum logic [4:0] {
        S_IDLE, S_RD_WAIT, S_HR_WAIT, S_CLEAR, S_PASS_SEL, S_INIT0, S_INIT1,
        S_E_RDT, S_E_RDP, S_E_CMP, S_E_RDN, S_E_WRT,
        S_H_RD0, S_H_WR0, S_H_RD1, S_H_WR1
    } state_t;

    state_t                           state_reg;
    logic                             out_valid_reg;
    shs_pkg::res_t                    res_reg;
    logic [shs_pkg::MAX_GAPS-1:0]     pass_valid_reg;
    logic [shs_pkg::LVL_W-1:0]        maxima_reg [shs_pkg::MAX_GAPS][2];
    logic [shs_pkg::HADDR_W-1:0]      clr_reg;
    logic [2:0]                       p_reg;
    logic [2:0]                       pos_reg;
    logic [shs_pkg::GAP_W-1:0]        gap_reg;
    logic [shs_pkg::LEN_W-1:0]        i_reg;
    logic [shs_pkg::IDX_W-1:0]        j_reg;
    logic [shs_pkg::IDX_W-1:0]        depth_reg;
    logic [shs_pkg::LVL_W-1:0]        comps_reg;
    logic [shs_pkg::DATA_WIDTH-1:0]   t_reg;
    logic [shs_pkg::LVL_W-1:0]        lvl_reg;

    logic [shs_pkg::LEN_W-1:0]        len_eff;
    logic [2:0]                       n_eff;
    logic                             accept;
    logic                             idx_ok;
    logic                             hist_ok;
    logic [2:0]                       psel_safe;
    logic [shs_pkg::GAP_W-1:0]        gap_sel;
    logic [shs_pkg::IDX_W-1:0]        j_back;
    logic [shs_pkg::BIN_W-1:0]        dbin;
    logic [shs_pkg::BIN_W-1:0]        cbin;
    logic [shs_pkg::LEN_W-1:0]        i_inc;
    logic                             do_shift;

    // effective length and gap count
    assign len_eff = (cfg.array_length > shs_pkg::LEN_W'(shs_pkg::MAX_LEN))
                   ? shs_pkg::LEN_W'(shs_pkg::MAX_LEN) : cfg.array_length;
    assign n_eff   = (cfg.gap_count > 3'(shs_pkg::MAX_GAPS))
                   ? 3'(shs_pkg::MAX_GAPS) : cfg.gap_count;

    // request checks
    assign accept    = in_valid && in_ready;
    assign idx_ok    = {1'b0, req.elem_index} < len_eff;
    assign psel_safe = (req.pass_select < 3'(shs_pkg::MAX_GAPS)) ? req.pass_select : 3'd0;
    assign hist_ok   = (req.pass_select < 3'(shs_pkg::MAX_GAPS))
                    && ({1'b0, req.bin_index} < 7'(shs_pkg::HIST_BINS))
                    && pass_valid_reg[psel_safe];

    // sequencer helpers
    assign gap_sel  = cfg.gap[p_reg - 3'd1];
    assign j_back   = j_reg - gap_reg;
    assign dbin     = (depth_reg >= shs_pkg::IDX_W'(shs_pkg::HIST_BINS - 1))
                    ? shs_pkg::BIN_W'(shs_pkg::HIST_BINS - 1) : depth_reg[shs_pkg::BIN_W-1:0];
    assign cbin     = (comps_reg >= shs_pkg::LVL_W'(shs_pkg::HIST_BINS - 1))
                    ? shs_pkg::BIN_W'(shs_pkg::HIST_BINS - 1) : comps_reg[shs_pkg::BIN_W-1:0];
    assign i_inc    = i_reg + 1'b1;
    assign do_shift = t_reg < e_rdata;

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    // memory port drive
    always_comb
    begin
        e_we    = 1'b0;
        e_addr  = i_reg[shs_pkg::IDX_W-1:0];
        e_wdata = t_reg;
        h_we    = 1'b0;
        h_addr  = {psel_safe, req.hist_kind, req.bin_index};
        h_wdata = 32'd0;
        unique case (state_reg)
            S_IDLE:
            begin
                e_addr  = req.elem_index;
                e_wdata = req.elem_value;
                e_we    = accept && (req.req_type == shs_pkg::REQ_WRITE) && idx_ok;
            end
            S_E_RDP, S_E_RDN:
            begin
                e_addr = j_back;
            end
            S_E_CMP:
            begin
                e_addr  = j_reg;
                e_wdata = e_rdata;
                e_we    = do_shift;
            end
            S_E_WRT:
            begin
                e_addr = j_reg;
                e_we   = 1'b1;
            end
            S_CLEAR:
            begin
                h_addr = clr_reg;
                h_we   = 1'b1;
            end
            S_INIT0:
            begin
                h_addr  = {pos_reg, 1'b0, shs_pkg::BIN_W'(0)};
                h_wdata = 32'(gap_reg);
                h_we    = 1'b1;
            end
            S_INIT1:
            begin
                h_addr  = {pos_reg, 1'b1, shs_pkg::BIN_W'(0)};
                h_wdata = 32'(gap_reg);
                h_we    = 1'b1;
            end
            S_H_RD0:
            begin
                h_addr = {pos_reg, 1'b0, dbin};
            end
            S_H_WR0:
            begin
                h_addr  = {pos_reg, 1'b0, dbin};
                h_wdata = (h_rdata == '1) ? h_rdata : h_rdata + 32'd1;
                h_we    = 1'b1;
            end
            S_H_RD1:
            begin
                h_addr = {pos_reg, 1'b1, cbin};
            end
            S_H_WR1:
            begin
                h_addr  = {pos_reg, 1'b1, cbin};
                h_wdata = (h_rdata == '1) ? h_rdata : h_rdata + 32'd1;
                h_we    = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // state, sequencer registers and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            pass_valid_reg <= '0;
            for (int p = 0; p < shs_pkg::MAX_GAPS; p++)
            begin
                maxima_reg[p][0] <= '0;
                maxima_reg[p][1] <= '0;
            end
            clr_reg   <= '0;
            p_reg     <= '0;
            pos_reg   <= '0;
            gap_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            depth_reg <= '0;
            comps_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_reg <= '0;
                        case (req.req_type)
                            shs_pkg::REQ_WRITE:
                            begin
                                res_reg.status <= !idx_ok;
                                out_valid_reg  <= 1'b1;
                            end
                            shs_pkg::REQ_RUN:
                            begin
                                pass_valid_reg <= '0;
                                for (int p = 0; p < shs_pkg::MAX_GAPS; p++)
                                begin
                                    maxima_reg[p][0] <= '0;
                                    maxima_reg[p][1] <= '0;
                                end
                                clr_reg   <= '0;
                                p_reg     <= n_eff;
                                state_reg <= S_CLEAR;
                            end
                            shs_pkg::REQ_READ:
                            begin
                                if (idx_ok)
                                begin
                                    state_reg <= S_RD_WAIT;
                                end
                                else
                                begin
                                    res_reg.status <= 1'b1;
                                    out_valid_reg  <= 1'b1;
                                end
                            end
                            default:
                            begin
                                if (hist_ok)
                                begin
                                    lvl_reg   <= maxima_reg[psel_safe][req.hist_kind];
                                    state_reg <= S_HR_WAIT;
                                end
                                else
                                begin
                                    res_reg.status <= 1'b1;
                                    out_valid_reg  <= 1'b1;
                                end
                            end
                        endcase
                    end
                end
                S_RD_WAIT:
                begin
                    res_reg.read_data <= e_rdata;
                    out_valid_reg     <= 1'b1;
                    state_reg         <= S_IDLE;
                end
                S_HR_WAIT:
                begin
                    res_reg.bin_count <= h_rdata;
                    res_reg.max_level <= lvl_reg;
                    out_valid_reg     <= 1'b1;
                    state_reg         <= S_IDLE;
                end
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == shs_pkg::HADDR_W'(shs_pkg::HIST_DEPTH - 1))
                    begin
                        state_reg <= S_PASS_SEL;
                    end
                end
                S_PASS_SEL:
                begin
                    if (p_reg == 3'd0)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        p_reg <= p_reg - 3'd1;
                        if ((gap_sel != '0) && ({1'b0, gap_sel} < len_eff))
                        begin
                            pos_reg   <= p_reg - 3'd1;
                            gap_reg   <= gap_sel;
                            state_reg <= S_INIT0;
                        end
                    end
                end
                S_INIT0:
                begin
                    state_reg <= S_INIT1;
                end
                S_INIT1:
                begin
                    pass_valid_reg[pos_reg] <= 1'b1;
                    i_reg                   <= {1'b0, gap_reg};
                    state_reg               <= S_E_RDT;
                end
                S_E_RDT:
                begin
                    j_reg     <= i_reg[shs_pkg::IDX_W-1:0];
                    depth_reg <= '0;
                    comps_reg <= shs_pkg::LVL_W'(1);
                    state_reg <= S_E_RDP;
                end
                S_E_RDP:
                begin
                    t_reg     <= e_rdata;
                    state_reg <= S_E_CMP;
                end
                S_E_CMP:
                begin
                    if (do_shift)
                    begin
                        depth_reg <= depth_reg + 1'b1;
                        j_reg     <= j_back;
                        if (j_back < gap_reg)
                        begin
                            state_reg <= S_E_WRT;
                        end
                        else
                        begin
                            comps_reg <= comps_reg + 1'b1;
                            state_reg <= S_E_RDN;
                        end
                    end
                    else if (depth_reg != '0)
                    begin
                        // held element goes into the hole left by the shifts
                        state_reg <= S_E_WRT;
                    end
                    else
                    begin
                        state_reg <= S_H_RD0;
                    end
                end
                S_E_RDN:
                begin
                    state_reg <= S_E_CMP;
                end
                S_E_WRT:
                begin
                    state_reg <= S_H_RD0;
                end
                S_H_RD0:
                begin
                    if ({1'b0, depth_reg} > maxima_reg[pos_reg][0])
                    begin
                        maxima_reg[pos_reg][0] <= {1'b0, depth_reg};
                    end
                    if (comps_reg > maxima_reg[pos_reg][1])
                    begin
                        maxima_reg[pos_reg][1] <= comps_reg;
                    end
                    state_reg <= S_H_WR0;
                end
                S_H_WR0:
                begin
                    state_reg <= S_H_RD1;
                end
                S_H_RD1:
                begin
                    state_reg <= S_H_WR1;
                end
                S_H_WR1:
                begin
                    i_reg <= i_inc;
                    if (i_inc < len_eff)
                    begin
                        state_reg <= S_E_RDT;
                    end
                    else
                    begin
                        state_reg <= S_PASS_SEL;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // a new item is taken only with the result register empty
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid_reg)
        else $error("item accepted while a result is pending");

    // element writes from a request stay inside the effective length
    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        (e_we && (state_reg == S_IDLE)) |-> ({1'b0, e_addr} < len_eff))
        else $error("element write beyond length");

    // histogram writes stay inside the histogram memory
    a_hist_range: assert property (@(posedge clk) disable iff (!rst_n)
        h_we |-> (h_addr < shs_pkg::HADDR_W'(shs_pkg::HIST_DEPTH)))
        else $error("histogram write out of range");

    // a run request keeps the block busy on the next cycle
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.req_type == shs_pkg::REQ_RUN)) |=> !in_ready)
        else $error("ready right after run request");
`endif

endmodule

// ----- src/instrumented_shellsort_unit.sv -----
// top level of the instrumented shellsort unit: ports, registers, memories
`timescale 1ns / 1ps

// Element store of 4096 x 32 bits written and read by index, and an in-place
// Shellsort over the first array_length elements with per-pass histograms of
// shift depth and comparison count. Element writes and requests that fail
// their range check give their result in the cycle after acceptance; element
// and histogram reads pass through the registered memory read and a wait
// state. A run request first clears the 768-entry histogram memory, one
// entry a cycle, then steps through each gap table position in use from the
// highest down; each pass that runs starts with the setup states S_INIT0 and
// S_INIT1. Per element a pass reads the held element and the one a gap below
// it, shifts each larger one up by one gap until the bottom of the gap chain,
// writes the held element into the hole if it shifted, then updates both
// histograms by read-modify-write on the single-port memories. The block
// takes no item until its result has been taken. Configuration writes are
// accepted at any time.
module instrumented_shellsort_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // elem_index[11:0], elem_value[43:12], pass_select[46:44], bin_index[52:47]
    input  logic [55:0] s_tdata,
    // req_type[1:0], hist_kind[2]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[31:0], bin_count[63:32], max_level[76:64]
    output logic [79:0] m_tdata,
    // status[0]
    output logic [0:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    shs_pkg::cfg_t                         cfg_reg;
    shs_pkg::req_t                         req;
    shs_pkg::res_t                         res;
    logic                                  e_we;
    logic [shs_pkg::IDX_W-1:0]             e_addr;
    logic [shs_pkg::DATA_WIDTH-1:0]        e_wdata;
    logic [shs_pkg::DATA_WIDTH-1:0]        e_rdata;
    logic                                  h_we;
    logic [shs_pkg::HADDR_W-1:0]           h_addr;
    logic [31:0]                           h_wdata;
    logic [31:0]                           h_rdata;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.array_length <= 13'd4096;
            cfg_reg.gap_count    <= 3'd1;
            cfg_reg.gap[0]       <= 12'd1;
            cfg_reg.gap[1]       <= 12'd4;
            cfg_reg.gap[2]       <= 12'd13;
            cfg_reg.gap[3]       <= 12'd40;
            cfg_reg.gap[4]       <= 12'd121;
            cfg_reg.gap[5]       <= 12'd364;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                shs_pkg::REG_LENGTH: cfg_reg.array_length <= cfg_data;
                shs_pkg::REG_GCOUNT: cfg_reg.gap_count    <= cfg_data[2:0];
                shs_pkg::REG_GAP0:   cfg_reg.gap[0]       <= cfg_data[11:0];
                shs_pkg::REG_GAP1:   cfg_reg.gap[1]       <= cfg_data[11:0];
                shs_pkg::REG_GAP2:   cfg_reg.gap[2]       <= cfg_data[11:0];
                shs_pkg::REG_GAP3:   cfg_reg.gap[3]       <= cfg_data[11:0];
                shs_pkg::REG_GAP4:   cfg_reg.gap[4]       <= cfg_data[11:0];
                default:             cfg_reg.gap[5]       <= cfg_data[11:0];
            endcase
        end
    end

    // stream field unpacking and packing
    assign req.req_type    = s_tuser[1:0];
    assign req.hist_kind   = s_tuser[2];
    assign req.elem_index  = s_tdata[11:0];
    assign req.elem_value  = s_tdata[43:12];
    assign req.pass_select = s_tdata[46:44];
    assign req.bin_index   = s_tdata[52:47];

    assign m_tdata = {3'b000, res.max_level, res.bin_count, res.read_data};
    assign m_tuser = res.status;

    // sequencer
    shs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .req       (req),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res       (res),
        .e_we      (e_we),
        .e_addr    (e_addr),
        .e_wdata   (e_wdata),
        .e_rdata   (e_rdata),
        .h_we      (h_we),
        .h_addr    (h_addr),
        .h_wdata   (h_wdata),
        .h_rdata   (h_rdata)
    );

    // element memory
    shs_ram #(
        .WIDTH (shs_pkg::DATA_WIDTH),
        .DEPTH (shs_pkg::MAX_LEN)
    ) u_elem_ram (
        .clk   (clk),
        .we    (e_we),
        .addr  (e_addr),
        .wdata (e_wdata),
        .rdata (e_rdata)
    );

    // histogram memory
    shs_ram #(
        .WIDTH (32),
        .DEPTH (shs_pkg::HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (h_we),
        .addr  (h_addr),
        .wdata (h_wdata),
        .rdata (h_rdata)
    );

endmodule
